### design/vector3_normalize_core_assert.svh
// assertion macros shared by the core
`ifndef VECTOR3_NORMALIZE_CORE_ASSERT_SVH
`define VECTOR3_NORMALIZE_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VN_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vector3_normalize_core: check failed");

// antecedent implies consequent in the following cycle
`define VN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vector3_normalize_core: check failed");

`endif

### design/vn_pkg.sv
`default_nettype none
package vn_pkg;
  localparam int COMP_WIDTH = 32;
  localparam int IO_W = 32;
  localparam int SUM_W = 2 * COMP_WIDTH;
  localparam int REM_W = COMP_WIDTH + 2;
  localparam int SQ_STAGES = COMP_WIDTH;
  localparam int DIV_STAGES = COMP_WIDTH - 2;
  localparam int UNIT_FRAC = COMP_WIDTH - 3;
  localparam int TOTAL_STAGES = 3 + SQ_STAGES + DIV_STAGES;

  typedef struct packed {
    logic                  neg;
    logic [COMP_WIDTH-1:0] mag;
  } comp_t;

  // port field to internal width, sign extended
  function automatic logic [COMP_WIDTH-1:0] ext_comp(input logic [IO_W-1:0] f);
    logic [IO_W+COMP_WIDTH-1:0] t;
    t = {{COMP_WIDTH{f[IO_W-1]}}, f};
    return t[COMP_WIDTH-1:0];
  endfunction

  function automatic logic [IO_W-1:0] to_io_s(input logic [COMP_WIDTH-1:0] v);
    logic [IO_W+COMP_WIDTH-1:0] t;
    t = {{IO_W{v[COMP_WIDTH-1]}}, v};
    return t[IO_W-1:0];
  endfunction

  function automatic logic [IO_W-1:0] to_io_u(input logic [COMP_WIDTH-1:0] v);
    logic [IO_W+COMP_WIDTH-1:0] t;
    t = {{IO_W{1'b0}}, v};
    return t[IO_W-1:0];
  endfunction
endpackage
`default_nettype wire

### design/vector3_normalize_core.sv
`default_nettype none
`include "vector3_normalize_core_assert.svh"
// Normalizes one 3D vector of signed Q16.16 components per item and returns
// Q2.29 unit components, the truncated Q16.16 magnitude and a zero flag; a
// zero vector comes back unchanged with zero_length set. Fully pipelined: a
// new item is taken every cycle while no result is held at the output, and
// each result passes the input registers, the one-bit-per-stage square root,
// three parallel one-bit-per-stage divider lanes and the output register.
// in_stall rises only while a result is held at the output by out_stall.
module vector3_normalize_core (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [vn_pkg::IO_W-1:0] vec_x,
  input  wire logic signed [vn_pkg::IO_W-1:0] vec_y,
  input  wire logic signed [vn_pkg::IO_W-1:0] vec_z,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [vn_pkg::IO_W-1:0] unit_x,
  output logic signed [vn_pkg::IO_W-1:0] unit_y,
  output logic signed [vn_pkg::IO_W-1:0] unit_z,
  output logic        [vn_pkg::IO_W-1:0] length,
  output logic                         zero_length
);
  import vn_pkg::*;

  logic                  en;
  logic [COMP_WIDTH-1:0] raw [3];
  comp_t                 c1 [3];
  comp_t                 c2 [3];
  comp_t                 c3 [3];
  logic [SUM_W-1:0]      sq [3];
  logic [SUM_W-1:0]      sum;
  comp_t                 cd [SQ_STAGES][3];
  logic [COMP_WIDTH-1:0] root;
  logic [COMP_WIDTH-1:0] ld [DIV_STAGES];
  logic [COMP_WIDTH-1:0] unit_q [3];
  logic                  vld [TOTAL_STAGES];
  logic                  len_zero;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign raw[0] = ext_comp(vec_x);
  assign raw[1] = ext_comp(vec_y);
  assign raw[2] = ext_comp(vec_z);

  // abs value, squares, then the sum
  for (genvar i = 0; i < 3; i++) begin : g_lane_front
    logic [SUM_W-1:0] prod;
    assign prod = c1[i].mag * c1[i].mag;

    always_ff @(posedge clk) begin
      if (en) begin
        c1[i].neg <= raw[i][COMP_WIDTH-1];
        c1[i].mag <= raw[i][COMP_WIDTH-1] ? (COMP_WIDTH'(0) - raw[i]) : raw[i];
        sq[i]     <= prod;
        c2[i]     <= c1[i];
        c3[i]     <= c2[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sq[0] + sq[1] + sq[2];
    end
  end

  vn_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum),
    .root     (root)
  );

  // components wait alongside the square root, and the root alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SQ_STAGES; s++) begin
        for (int i = 0; i < 3; i++) begin
          cd[s][i] <= (s == 0) ? c3[i] : cd[(s == 0) ? 0 : s - 1][i];
        end
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
        ld[s] <= (s == 0) ? root : ld[(s == 0) ? 0 : s - 1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    vn_div u_div (
      .clk  (clk),
      .en   (en),
      .comp (cd[SQ_STAGES-1][i]),
      .len  (root),
      .unit (unit_q[i])
    );
  end

  assign len_zero = (ld[DIV_STAGES-1] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < TOTAL_STAGES; s++) begin
        vld[s] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s < TOTAL_STAGES; s++) begin
        vld[s] <= vld[s-1];
      end
      out_valid <= vld[TOTAL_STAGES-1];
    end
  end

  // merge: a zero vector passes through, which is all zeros
  always_ff @(posedge clk) begin
    if (en) begin
      unit_x      <= len_zero ? '0 : to_io_s(unit_q[0]);
      unit_y      <= len_zero ? '0 : to_io_s(unit_q[1]);
      unit_z      <= len_zero ? '0 : to_io_s(unit_q[2]);
      length      <= to_io_u(ld[DIV_STAGES-1]);
      zero_length <= len_zero;
    end
  end

  `VN_ASSERT_SAME(a_stall_only_when_held, 1'b1, in_stall == (out_valid && out_stall))
  `VN_ASSERT_SAME(a_zero_clean, out_valid && zero_length,
    unit_x == 0 && unit_y == 0 && unit_z == 0 && length == 0)
  `VN_ASSERT_SAME(a_nonzero_len, out_valid && !zero_length, length != 0)
  `VN_ASSERT_NEXT(a_held_result, out_valid && out_stall && !rst, out_valid)
endmodule
`default_nettype wire

### design/vn_sqrt.sv
`default_nettype none
module vn_sqrt (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [vn_pkg::SUM_W-1:0]      radicand,
  output logic      [vn_pkg::COMP_WIDTH-1:0] root
);
  import vn_pkg::*;

  logic [REM_W-1:0]      rem_q  [SQ_STAGES];
  logic [COMP_WIDTH-1:0] root_q [SQ_STAGES];
  logic [SUM_W-1:0]      rad_q  [SQ_STAGES];

  // one root bit per stage, two radicand bits consumed per stage
  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic [REM_W-1:0]      prem;
    logic [COMP_WIDTH-1:0] proot;
    logic [SUM_W-1:0]      prad;
    logic [REM_W+1:0]      sh;
    logic [REM_W+1:0]      trial;
    logic                  ge;

    if (g == 0) begin : g_first
      assign prem  = '0;
      assign proot = '0;
      assign prad  = radicand;
    end else begin : g_next
      assign prem  = rem_q[g-1];
      assign proot = root_q[g-1];
      assign prad  = rad_q[g-1];
    end

    assign sh    = {prem, prad[SUM_W-1 -: 2]};
    assign trial = {2'b00, proot, 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g]  <= ge ? REM_W'(sh - trial) : REM_W'(sh);
        root_q[g] <= {proot[COMP_WIDTH-2:0], ge};
        rad_q[g]  <= {prad[SUM_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[SQ_STAGES-1];
endmodule
`default_nettype wire

### design/vn_div.sv
`default_nettype none
module vn_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire vn_pkg::comp_t                 comp,
  input  wire logic [vn_pkg::COMP_WIDTH-1:0] len,
  output logic      [vn_pkg::COMP_WIDTH-1:0] unit
);
  import vn_pkg::*;

  logic [COMP_WIDTH-1:0] rem_q [DIV_STAGES];
  logic [COMP_WIDTH-1:0] quo_q [DIV_STAGES];
  logic [COMP_WIDTH-1:0] len_q [DIV_STAGES];
  logic                  neg_q [DIV_STAGES];

  // dividend is mag << UNIT_FRAC; the quotient never exceeds 2^UNIT_FRAC
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [COMP_WIDTH-1:0] prem;
    logic [COMP_WIDTH-1:0] pquo;
    logic [COMP_WIDTH-1:0] plen;
    logic                  pneg;
    logic                  bit_in;
    logic [COMP_WIDTH:0]   sh;
    logic                  ge;

    if (g == 0) begin : g_first
      assign prem   = {1'b0, comp.mag[COMP_WIDTH-1:1]};
      assign pquo   = '0;
      assign plen   = len;
      assign pneg   = comp.neg;
      assign bit_in = comp.mag[0];
    end else begin : g_next
      assign prem   = rem_q[g-1];
      assign pquo   = quo_q[g-1];
      assign plen   = len_q[g-1];
      assign pneg   = neg_q[g-1];
      assign bit_in = 1'b0;
    end

    assign sh = {prem, bit_in};
    assign ge = (sh >= {1'b0, plen});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g] <= ge ? COMP_WIDTH'(sh - {1'b0, plen}) : COMP_WIDTH'(sh);
        quo_q[g] <= {pquo[COMP_WIDTH-2:0], ge};
        len_q[g] <= plen;
        neg_q[g] <= pneg;
      end
    end
  end

  assign unit = neg_q[DIV_STAGES-1] ? (COMP_WIDTH'(0) - quo_q[DIV_STAGES-1])
                                    : quo_q[DIV_STAGES-1];
endmodule
`default_nettype wire

### dv/tb_vector3_normalize_core.sv
`default_nettype none
module tb_vector3_normalize_core;
  import vn_pkg::*;

  localparam int LATENCY = TOTAL_STAGES + 1;

  typedef struct packed {
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] uz;
    logic [31:0] len;
    logic        zero;
  } norm_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic signed [31:0] vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] unit_x;
  logic signed [31:0] unit_y;
  logic signed [31:0] unit_z;
  logic [31:0] length;
  logic zero_length;

  norm_t expected_norms[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int zero_vectors = 0;

  vector3_normalize_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
    .length(length), .zero_length(zero_length)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] abs32(input logic [31:0] c);
    return c[31] ? (~c + 32'd1) : c;
  endfunction

  function automatic logic [31:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[31:0];
  endfunction

  // sign(c) * floor(|c| * 2^29 / len), magnitudes never exceed len
  function automatic logic [31:0] unit_comp(input logic [31:0] c, input logic [31:0] len);
    logic [63:0] q;
    q = ({32'd0, abs32(c)} << UNIT_FRAC) / {32'd0, len};
    return c[31] ? (~q[31:0] + 32'd1) : q[31:0];
  endfunction

  function automatic norm_t normalize(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z);
    norm_t r;
    logic [63:0] ax, ay, az;
    logic [65:0] sum;
    logic [31:0] len;
    ax = {32'd0, abs32(x)};
    ay = {32'd0, abs32(y)};
    az = {32'd0, abs32(z)};
    sum = ax * ax + ay * ay + az * az;
    len = int_sqrt(sum[63:0]);
    if (len == 0) begin
      r = '{x, y, z, 32'd0, 1'b1};
    end else begin
      r = '{unit_comp(x, len), unit_comp(y, len), unit_comp(z, len), len, 1'b0};
    end
    return r;
  endfunction

  // valid stays high after an accept so a following item can go back to back
  task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    vec_x <= x;
    vec_y <= y;
    vec_z <= z;
    expected_norms.push_back(normalize(x, y, z));
    if (x == 0 && y == 0 && z == 0) zero_vectors++;
    items_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // result receiver with random stall
  initial begin
    norm_t exp_n;
    int hold;
    @(negedge rst);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      if (expected_norms.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        exp_n = expected_norms.pop_front();
        if (unit_x !== exp_n.ux) begin
          $error("unit_x expected %h got %h", exp_n.ux, unit_x); errors++;
        end
        if (unit_y !== exp_n.uy) begin
          $error("unit_y expected %h got %h", exp_n.uy, unit_y); errors++;
        end
        if (unit_z !== exp_n.uz) begin
          $error("unit_z expected %h got %h", exp_n.uz, unit_z); errors++;
        end
        if (length !== exp_n.len) begin
          $error("length expected %h got %h", exp_n.len, length); errors++;
        end
        if (zero_length !== exp_n.zero) begin
          $error("zero_length expected %b got %b", exp_n.zero, zero_length); errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_norms.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    logic [31:0] vals[6];
    vals = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h1, 32'h0001_0000};
    send_vector(0, 0, 0);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vector(32'h1, 0, 0);
    send_vector(0, 32'hffff_ffff, 0);
    send_vector(0, 0, 32'h0001_0000);
    send_vector(32'h8000_0000, 0, 0);
    send_vector(32'h0003_0000, 32'hfffc_0000, 0);
    for (int i = 0; i < 12; i++)
      send_vector(vals[$urandom_range(0, 5)], vals[$urandom_range(0, 5)],
                  vals[$urandom_range(0, 5)]);
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_vector($urandom, $urandom, $urandom);
    send_vector(0, 0, 0);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 15) - 8;
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return 32'($signed($urandom)) >>> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_vector(rand_comp(), rand_comp(), rand_comp());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_drain_pause();
    test_random(1130);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d vectors, %0d zero vectors; checked %0d results",
             items_sent, zero_vectors, results_seen);
    if (errors == 0 && expected_norms.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
